// ===== rtl/agrac_pkg.sv =====
// Shared types, register codes and calibration constants for the ADC averaging block.
`timescale 1ns / 1ps

package agrac_pkg;

	// Field widths of the channels.
	localparam int RAW_W = 13;
	localparam int CAL_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t REG_JUMP_THRESHOLD = 2'd0;
	localparam cfg_idx_t REG_DISCARD_LIMIT = 2'd1;
	localparam cfg_idx_t REG_SLOPE = 2'd2;
	localparam cfg_idx_t REG_OFFSET = 2'd3;

	// Register widths and reset values.
	localparam int THR_W = 12;
	localparam int LIM_W = 4;
	localparam int RUN_W = 5;
	localparam logic [THR_W-1:0] THR_RESET = 12'd5;
	localparam logic [LIM_W-1:0] LIM_RESET = 4'd5;
	localparam logic signed [15:0] SLOPE_RESET = 16'sd10000;
	localparam logic signed [15:0] OFFSET_RESET = 16'sd0;

	// Calibration: n = avg*slope + 10*offset + 5000, result = n / 10000.
	// The numerator is signed and below 2^28 in magnitude.
	localparam int CAL_NUM_W = 30;
	localparam int CAL_OFF_SCALE = 10;
	localparam int CAL_ROUND = 5000;
	// Division of a 28-bit value by 10000 as a multiply by ceil(2^42 / 10000).
	localparam int CAL_POS_W = 28;
	localparam int CAL_RECIP_W = 29;
	localparam int CAL_SHIFT = 42;
	localparam logic [CAL_RECIP_W-1:0] CAL_RECIP = 29'd439804652;
	localparam int CAL_PROD_W = CAL_POS_W + CAL_RECIP_W;
	// The quotient never exceeds 26843, so 15 bits hold it and no clamp is needed.
	localparam int CAL_Q_W = 15;

endpackage

// ===== rtl/agrac_sample_if.sv =====
// Sample channel interface carrying one raw ADC code per item.
`timescale 1ns / 1ps

interface agrac_sample_if;
	logic valid;
	logic ready;
	logic [agrac_pkg::RAW_W-1:0] raw_code;

	modport source (output valid, output raw_code, input ready);
	modport sink (input valid, input raw_code, output ready);
endinterface

// ===== rtl/agrac_result_if.sv =====
// Result channel interface carrying the block average and the calibrated value.
`timescale 1ns / 1ps

interface agrac_result_if;
	logic valid;
	logic ready;
	logic signed [agrac_pkg::RAW_W-1:0] block_average;
	logic [agrac_pkg::CAL_W-1:0] calibrated_value;

	modport source (output valid, output block_average, output calibrated_value, input ready);
	modport sink (input valid, input block_average, input calibrated_value, output ready);
endinterface

// ===== rtl/agrac_cfg_if.sv =====
// Configuration write channel interface: register index and write data.
`timescale 1ns / 1ps

interface agrac_cfg_if;
	logic valid;
	logic ready;
	agrac_pkg::cfg_idx_t index;
	logic [agrac_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/adc_glitch_reject_average_calibrate.sv =====
// ADC glitch filter with block averaging and linear calibration (top level).
`timescale 1ns / 1ps
// Usage:
// Raw 13-bit two's complement ADC codes arrive as items on the samples channel.
// A negative code is folded to its magnitude, then a jump filter replaces codes
// that leave the window of +/- jump_threshold around the last accepted sample,
// until discard_limit replacements in a row have been made in one direction.
// Filtered samples are summed; every AVERAGE_COUNT-th item produces one result
// item on the results channel with the floor average and the calibrated value
// round(avg*slope/10000 + offset/1000), clamped at zero. Other items give none.
// Throughput: one sample item per cycle, except while a block-closing item waits
// as described below. The sample stage updates its state in the cycle of
// acceptance; the result then goes through the registered stages sum register,
// average multiply, calibration multiply, reciprocal multiply and output register.
// When the receiver stalls, the result pipeline holds its items; samples keep
// flowing, and only the item that closes a block waits while the first result
// stage cannot take its sum.
// The cfg channel is always ready; writes are registered and should be made
// while no sample or result is in flight.
// Reset (arst_n low) restores the register defaults, clears the filter state,
// the running sum and the sample count, and empties the result pipeline.

module adc_glitch_reject_average_calibrate #(
	parameter int AVERAGE_COUNT = 16
) (
	input logic clk,
	input logic arst_n,
	agrac_sample_if.sink samples,
	agrac_result_if.source results,
	agrac_cfg_if.sink cfg
);

	localparam int RawW = agrac_pkg::RAW_W;
	localparam int RunW = agrac_pkg::RUN_W;
	localparam int CntW = $clog2(AVERAGE_COUNT);
	// The sum spans -4096*N .. 4095*N.
	localparam int SumW = RawW + CntW;
	// Floor division of the biased sum by N as an exact reciprocal multiply.
	localparam int DivK = SumW + CntW;
	localparam longint DivM = ((longint'(1) <<< DivK) + AVERAGE_COUNT - 1) / AVERAGE_COUNT;
	localparam int MulW = SumW + 2;
	localparam int DivPW = SumW + MulW;
	localparam logic [MulW-1:0] DivMul = MulW'(DivM);
	localparam logic [SumW-1:0] SumBias = SumW'(longint'(4096) * AVERAGE_COUNT);
	localparam logic [CntW-1:0] CntLast = CntW'(AVERAGE_COUNT - 1);
	localparam int NumW = agrac_pkg::CAL_NUM_W;
	localparam logic signed [RunW-1:0] RunMin = {1'b1, {(RunW-1){1'b0}}};

	// Configuration registers.
	logic [agrac_pkg::THR_W-1:0] thr_q;
	logic [agrac_pkg::LIM_W-1:0] lim_q;
	logic signed [15:0] slope_q;
	logic signed [15:0] offset_q;

	// Filter and accumulator state.
	logic signed [RawW-1:0] last_q;
	logic signed [RunW-1:0] run_q;
	logic signed [SumW-1:0] sum_q;
	logic [CntW-1:0] cnt_q;

	// Result pipeline.
	logic v_s1, v_s2, v_s3, v_s4, out_v_q;
	logic signed [SumW-1:0] sum_s1;
	logic [DivPW-1:0] dprod_s2;
	logic signed [RawW-1:0] avg_s3, avg_s4;
	logic signed [NumW-1:0] n_s3;
	logic [agrac_pkg::CAL_PROD_W-1:0] cprod_s4;
	logic signed [RawW-1:0] out_avg_q;
	logic [agrac_pkg::CAL_W-1:0] out_cal_q;

	logic out_free, ld4, ld3, ld2, ld1;
	logic acc, closing;

	// Filter datapath.
	logic signed [RawW-1:0] samp;
	logic signed [RawW:0] samp_x, last_x, thr_x, lo_lim, hi_lim;
	logic signed [RunW-1:0] lim_x;
	logic go_below, go_above;
	logic signed [RawW-1:0] filt;
	logic signed [RunW-1:0] run_d;
	logic signed [SumW-1:0] sum_d;

	// Calibration datapath.
	logic [SumW-1:0] div_x;
	logic [RawW-1:0] div_q;
	logic signed [RawW-1:0] avg_d;
	logic signed [NumW-1:0] avg_w, slope_w, off_w, n_d;

	// Each stage takes a new item when it is empty or its item moves on.
	assign out_free = !out_v_q || results.ready;
	assign ld4 = !v_s4 || out_free;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;

	// Only the item that closes a block needs room in the first result stage.
	assign samples.ready = (cnt_q != CntLast) || ld1;
	assign acc = samples.valid && samples.ready;
	assign closing = cnt_q == CntLast;

	assign cfg.ready = 1'b1;

	always_comb begin
		// The two's complement negation of a negative code is its magnitude;
		// the most negative code maps onto itself and stays -4096.
		samp = samples.raw_code[RawW-1] ? $signed(-samples.raw_code) : $signed(samples.raw_code);
		samp_x = (RawW+1)'(samp);
		last_x = (RawW+1)'(last_q);
		thr_x = $signed({2'b00, thr_q});
		lo_lim = last_x - thr_x;
		hi_lim = last_x + thr_x;
		lim_x = $signed({1'b0, lim_q});
		go_below = (samp_x < lo_lim) && (run_q > -lim_x);
		go_above = !go_below && (samp_x > hi_lim) && (run_q < lim_x);
		// A replacement against the current run direction stops at zero.
		if (go_below) begin
			filt = last_q;
			run_d = (run_q > 0) ? '0 : run_q - RunW'(1);
		end else if (go_above) begin
			filt = last_q;
			run_d = (run_q < 0) ? '0 : run_q + RunW'(1);
		end else begin
			filt = samp;
			run_d = '0;
		end
		sum_d = sum_q + SumW'(filt);
	end

	always_comb begin
		div_x = $unsigned(sum_s1) + SumBias;
		div_q = dprod_s2[DivK +: RawW];
		// Quotient of the biased sum minus 4096 is the floor average.
		avg_d = $signed(div_q - RawW'(4096));
		avg_w = NumW'(avg_d);
		slope_w = NumW'(slope_q);
		off_w = NumW'(offset_q);
		n_d = avg_w * slope_w + off_w * NumW'(agrac_pkg::CAL_OFF_SCALE)
			+ NumW'(agrac_pkg::CAL_ROUND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= agrac_pkg::THR_RESET;
			lim_q <= agrac_pkg::LIM_RESET;
			slope_q <= agrac_pkg::SLOPE_RESET;
			offset_q <= agrac_pkg::OFFSET_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				agrac_pkg::REG_JUMP_THRESHOLD: thr_q <= cfg.data[agrac_pkg::THR_W-1:0];
				agrac_pkg::REG_DISCARD_LIMIT: lim_q <= cfg.data[agrac_pkg::LIM_W-1:0];
				agrac_pkg::REG_SLOPE: slope_q <= $signed(cfg.data);
				agrac_pkg::REG_OFFSET: offset_q <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			run_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (acc) begin
			last_q <= filt;
			run_q <= run_d;
			if (closing) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_d;
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ld1) v_s1 <= acc && closing;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
			if (out_free) out_v_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) sum_s1 <= sum_d;
		if (ld2) dprod_s2 <= DivPW'(div_x) * DivPW'(DivMul);
		if (ld3) begin
			avg_s3 <= avg_d;
			n_s3 <= n_d;
		end
		if (ld4) begin
			avg_s4 <= avg_s3;
			// A negative numerator calibrates to zero.
			cprod_s4 <= n_s3[NumW-1] ? '0 :
				agrac_pkg::CAL_PROD_W'(n_s3[agrac_pkg::CAL_POS_W-1:0])
				* agrac_pkg::CAL_PROD_W'(agrac_pkg::CAL_RECIP);
		end
		if (out_free) begin
			out_avg_q <= avg_s4;
			out_cal_q <= {1'b0, cprod_s4[agrac_pkg::CAL_SHIFT +: agrac_pkg::CAL_Q_W]};
		end
	end

	assign results.valid = out_v_q;
	assign results.block_average = out_avg_q;
	assign results.calibrated_value = out_cal_q;

`ifndef SYNTH
	// The sample side only stalls on a closing item whose sum has no room.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> (cnt_q == CntLast && v_s1 && !ld2))
		else $error("sample stall without a blocked closing item");

	// Closing a block hands the sum to the result pipeline and restarts it.
	a_block_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && closing) |=> (v_s1 && cnt_q == '0 && sum_q == '0))
		else $error("block close did not restart the accumulator");

	// The run counter stays within the largest discard limit.
	a_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q != RunMin)
		else $error("run counter out of range");
`endif

endmodule
